// ----- rtl/core/gas_pkg.sv -----
// Shared constants for the gated action selector: fixed-point format,
// operation codes, status codes and configuration register indexes.
// No dependencies.
package gas_pkg;

	localparam int FB    = 16;          // fraction bits
	localparam int VW    = FB + 1;      // width of a unit value 0..1.0
	localparam int ONE   = 1 << FB;
	localparam int EPS   = (ONE + 5000) / 10000;
	localparam int AMTW  = FB + 2;      // signed amount width
	localparam int FUNCW = 3;
	localparam int IDXW  = 5;
	localparam int STW   = 2;
	localparam int CFGIW = 3;
	localparam int CFGDW = VW;
	localparam int AAW   = 6;           // active_actions width

	localparam logic [FUNCW-1:0] FUNC_RESTART = 3'd0;
	localparam logic [FUNCW-1:0] FUNC_WR_SAL  = 3'd1;
	localparam logic [FUNCW-1:0] FUNC_ADD_MOD = 3'd2;
	localparam logic [FUNCW-1:0] FUNC_SET_INH = 3'd3;
	localparam logic [FUNCW-1:0] FUNC_UPDATE  = 3'd4;
	localparam logic [FUNCW-1:0] FUNC_SELECT  = 3'd5;

	localparam logic [STW-1:0] ST_OK      = 2'd0;
	localparam logic [STW-1:0] ST_BAD_IDX = 2'd1;
	localparam logic [STW-1:0] ST_INH_DIS = 2'd2;

	localparam logic [CFGIW-1:0] REG_ACTIVE  = 3'd0;
	localparam logic [CFGIW-1:0] REG_BALANCE = 3'd1;
	localparam logic [CFGIW-1:0] REG_BASE    = 3'd2;
	localparam logic [CFGIW-1:0] REG_THRESH  = 3'd3;
	localparam logic [CFGIW-1:0] REG_GIE     = 3'd4;

endpackage

// ----- rtl/core/gas_ifs.sv -----
// Valid/ready channel interfaces of the gated action selector:
// request, response and configuration write. Depends on gas_pkg.
interface gas_req_if;
	logic                              valid;
	logic                              ready;
	logic [gas_pkg::FUNCW-1:0]         func;
	logic [gas_pkg::IDXW-1:0]          action_index;
	logic signed [gas_pkg::AMTW-1:0]   amount;
	modport source (output valid, func, action_index, amount, input ready);
	modport sink   (input valid, func, action_index, amount, output ready);
endinterface

interface gas_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [gas_pkg::STW-1:0]   status;
	logic [gas_pkg::IDXW-1:0]  winner;
	logic [gas_pkg::VW-1:0]    winner_confidence;
	logic                      weak_winner;
	logic [gas_pkg::VW-1:0]    conflict;
	logic [gas_pkg::VW-1:0]    mean_inhibition;
	logic [gas_pkg::VW-1:0]    modulator_now;
	modport source (output valid, status, winner, winner_confidence, weak_winner,
		conflict, mean_inhibition, modulator_now, input ready);
	modport sink   (input valid, status, winner, winner_confidence, weak_winner,
		conflict, mean_inhibition, modulator_now, output ready);
endinterface

interface gas_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [gas_pkg::CFGIW-1:0]   index;
	logic [gas_pkg::CFGDW-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/gated_action_selector.sv -----
// Gated action selector. Control items (restart, write salience, add modulator,
// set inhibition) go straight to the done state; select reads and compares each channel.
// Update runs the salience pass (read, multiply, accumulate per channel), then normalization
// of each channel on the shared bit-serial divider, then conflict, mean and modulator decay.
// One item at a time; a new item is taken while the last response waits. arst_n clears
// control state, valid bits of both memories and the other levels, and sets the modulator to one half.
module gated_action_selector #(
	parameter int MAX_CHANNELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	gas_req_if.sink     req,
	gas_rsp_if.source   rsp,
	gas_cfg_if.sink     cfg
);

	localparam int FB   = gas_pkg::FB;
	localparam int VW   = gas_pkg::VW;
	localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW   = $clog2(MAX_CHANNELS + 1);
	localparam int NW   = (CW > gas_pkg::AAW) ? CW : gas_pkg::AAW;
	localparam int TW   = VW + CW;
	localparam int DSW  = (TW > 21) ? TW : 21;
	localparam int DVW  = 2 * FB + 2;
	localparam int QW   = VW;
	localparam int DCW  = $clog2(QW + 1);
	localparam int PW   = 2 * VW + 1;
	localparam int IW   = FB + 5;
	// divide by ten as ceil(2^21/10) then shift; exact for values below 2^18
	localparam int DEC_SH  = 21;
	localparam int DEC_RCP = 209716;

	typedef enum logic [4:0] {
		S_IDLE, S_GAIN, S_P1_RD, S_P1_MUL, S_P1_ACC, S_P2_RD, S_P2_LD, S_P2_WR,
		S_CONF, S_CONF_WR, S_MEAN, S_MEAN_WR, S_DECAY, S_DECAY_MUL, S_DECAY_WR,
		S_SEL_RD, S_SEL_CMP, S_DIV, S_DONE
	} state_t;

	state_t state_q, div_ret_q;

	// configuration
	logic [gas_pkg::AAW-1:0] act_q;
	logic [VW-1:0] bal_q, base_q, thr_q;
	logic gie_q;

	// levels
	logic [VW-1:0] mod_q, gi_q, conflict_q, mean_q;

	// memories
	logic [VW-1:0] sal_mem [MAX_CHANNELS];
	logic [VW-1:0] prob_mem [MAX_CHANNELS];
	logic [MAX_CHANNELS-1:0] sal_vld_q, prob_vld_q;
	logic [VW-1:0] sal_rdata_q, prob_rdata_q;
	logic sal_rv_q, prob_rv_q;

	// work registers
	logic [CW-1:0] cnt_q;
	logic signed [gas_pkg::AMTW-1:0] amt_q;
	logic [VW:0] g1_q;
	logic [VW-1:0] g2_q;
	logic [VW:0] p1h_s2;
	logic [VW-1:0] p2h_s2;
	logic [TW-1:0] total_q, inhsum_q;
	logic [VW-1:0] mx_q, second_q, best_q;
	logic [gas_pkg::IDXW-1:0] win_q;
	logic sel_q, dec_neg_q;
	logic [gas_pkg::STW-1:0] status_q;
	logic [VW:0] dabs_q;
	logic [VW-1:0] dec_q;

	// divider
	logic [DSW-1:0] div_rem_q, div_den_q;
	logic [QW-1:0] div_num_q;
	logic [DCW-1:0] div_cnt_q;

	// response register
	logic rsp_valid_q;
	logic [gas_pkg::STW-1:0] rsp_status_q;
	logic [gas_pkg::IDXW-1:0] rsp_winner_q;
	logic [VW-1:0] rsp_conf_q, rsp_conflict_q, rsp_mean_q, rsp_mod_q;
	logic rsp_weak_q;

	function automatic logic [VW-1:0] sat_one(input logic [VW-1:0] v);
		return (v > VW'(gas_pkg::ONE)) ? VW'(gas_pkg::ONE) : v;
	endfunction

	function automatic logic [VW-1:0] clamp_s(input logic signed [IW-1:0] v);
		logic [VW-1:0] r;
		if (v < 0) r = '0;
		else if (v > IW'(gas_pkg::ONE)) r = VW'(gas_pkg::ONE);
		else r = v[VW-1:0];
		return r;
	endfunction

	// ---- combinational ----
	logic [CW-1:0] n_used, cnt_nx;
	logic [AW-1:0] rd_addr;
	logic [6:0] idx7;
	logic bad_idx, accept;
	logic [gas_pkg::STW-1:0] req_status;
	logic [VW-1:0] sal_val, prob_val, bal_s, base_s, amt_c;
	logic sal_we, prob_we;
	logic [AW-1:0] sal_wa;
	logic [VW-1:0] prob_wd;
	logic signed [IW-1:0] inh_raw;
	logic [VW-1:0] inh_c, act_v;
	logic [TW-1:0] total_nx, inhsum_nx;
	logic [PW-1:0] prod1, prod2, p1, p2;
	logic signed [VW+1:0] diff;
	logic signed [2*gas_pkg::AMTW+1:0] dprod;
	logic [DVW-1:0] dprod_abs;
	logic [2*VW+1:0] dec_prod;
	logic div_go;
	logic [DVW-1:0] div_dvd;
	logic [DSW-1:0] div_den;
	state_t div_ret;
	logic [DSW:0] div_t;
	logic div_ge;
	logic signed [IW-1:0] mod_sum, mod_dec;

	always_comb begin
		logic [NW-1:0] aa;
		aa = NW'(act_q);
		if (aa > NW'(MAX_CHANNELS)) n_used = CW'(MAX_CHANNELS);
		else n_used = CW'(aa);
	end

	assign cnt_nx   = cnt_q + 1'b1;
	assign rd_addr  = cnt_q[AW-1:0];
	assign idx7     = 7'(req.action_index);
	assign bad_idx  = idx7 >= 7'(n_used);
	assign req.ready = (state_q == S_IDLE);
	assign accept   = req.valid && (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign sal_val  = sal_rv_q ? sal_rdata_q : '0;
	assign prob_val = prob_rv_q ? prob_rdata_q : '0;
	assign bal_s    = sat_one(bal_q);
	assign base_s   = sat_one(base_q);
	assign amt_c    = clamp_s(IW'(req.amount));
	assign sal_wa   = idx7[AW-1:0];
	assign sal_we   = accept && (req.func == gas_pkg::FUNC_WR_SAL) && !bad_idx;

	always_comb begin
		req_status = gas_pkg::ST_OK;
		if ((req.func == gas_pkg::FUNC_WR_SAL) && bad_idx)
			req_status = gas_pkg::ST_BAD_IDX;
		else if ((req.func == gas_pkg::FUNC_SET_INH) && !gie_q)
			req_status = gas_pkg::ST_INH_DIS;
	end

	assign prod1 = PW'(bal_s) * (PW'(gas_pkg::ONE) + PW'(mod_q));
	assign prod2 = (PW'(gas_pkg::ONE) - PW'(bal_s)) *
		(PW'(gas_pkg::ONE) - PW'(mod_q >> 1));
	assign p1 = PW'(sal_val) * PW'(g1_q);
	assign p2 = PW'(sal_val) * PW'(g2_q);

	always_comb begin
		inh_raw = $signed(IW'(gas_pkg::ONE)) - $signed(IW'(p1h_s2)) + $signed(IW'(p2h_s2));
		if (gie_q) inh_raw = inh_raw + $signed(IW'(gi_q >> 1));
	end
	assign inh_c     = clamp_s(inh_raw);
	assign act_v     = VW'(gas_pkg::ONE) - inh_c;
	assign total_nx  = total_q + TW'(act_v);
	assign inhsum_nx = inhsum_q + TW'(inh_c);

	assign diff      = $signed((VW+2)'(base_s)) - $signed((VW+2)'(mod_q));
	assign dprod     = diff * amt_q;
	assign dprod_abs = dprod[2*gas_pkg::AMTW+1] ? DVW'(-dprod) : DVW'(dprod);
	assign dec_prod  = (2*VW+2)'(dabs_q) * (2*VW+2)'(DEC_RCP);

	assign mod_sum = $signed(IW'(mod_q)) + IW'(req.amount);
	assign mod_dec = dec_neg_q ? $signed(IW'(mod_q)) - $signed(IW'(dec_q))
		: $signed(IW'(mod_q)) + $signed(IW'(dec_q));

	always_comb begin
		prob_we = 1'b0;
		prob_wd = act_v;
		case (state_q)
			S_P1_ACC: prob_we = 1'b1;
			S_P2_WR: begin
				prob_we = 1'b1;
				prob_wd = div_num_q;
			end
			default: prob_we = 1'b0;
		endcase
	end

	always_comb begin
		div_go  = 1'b0;
		div_dvd = '0;
		div_den = '0;
		div_ret = S_IDLE;
		case (state_q)
			S_P2_LD: begin
				div_go  = 1'b1;
				div_dvd = DVW'(prob_val) << FB;
				div_den = DSW'(total_q);
				div_ret = S_P2_WR;
			end
			S_CONF: begin
				div_go  = second_q > VW'(gas_pkg::EPS);
				div_dvd = DVW'(second_q) << FB;
				div_den = DSW'(mx_q) + DSW'(gas_pkg::EPS);
				div_ret = S_CONF_WR;
			end
			S_MEAN: begin
				div_go  = n_used != '0;
				div_dvd = DVW'(inhsum_q);
				div_den = DSW'(n_used);
				div_ret = S_MEAN_WR;
			end
			default: div_go = 1'b0;
		endcase
	end

	assign div_t  = {div_rem_q, div_num_q[QW-1]};
	assign div_ge = div_t >= {1'b0, div_den_q};

	// ---- memories ----
	always_ff @(posedge clk) begin
		if (sal_we) sal_mem[sal_wa] <= amt_c;
		sal_rdata_q <= sal_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (prob_we) prob_mem[rd_addr] <= prob_wd;
		prob_rdata_q <= prob_mem[rd_addr];
	end

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= gas_pkg::AAW'(8);
			bal_q  <= VW'(32768);
			base_q <= VW'(32768);
			thr_q  <= VW'(39322);
			gie_q  <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				gas_pkg::REG_ACTIVE:  act_q  <= cfg.data[gas_pkg::AAW-1:0];
				gas_pkg::REG_BALANCE: bal_q  <= cfg.data;
				gas_pkg::REG_BASE:    base_q <= cfg.data;
				gas_pkg::REG_THRESH:  thr_q  <= cfg.data;
				gas_pkg::REG_GIE:     gie_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_ret_q   <= S_IDLE;
			mod_q       <= VW'(32768);
			gi_q        <= '0;
			conflict_q  <= '0;
			mean_q      <= '0;
			sal_vld_q   <= '0;
			prob_vld_q  <= '0;
			sal_rv_q    <= 1'b0;
			prob_rv_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
			sel_q       <= 1'b0;
		end else begin
			sal_rv_q  <= sal_vld_q[rd_addr];
			prob_rv_q <= prob_vld_q[rd_addr];
			// the done state reloads the slot itself
			if (rsp_valid_q && rsp.ready && (state_q != S_DONE)) rsp_valid_q <= 1'b0;
			if (sal_we) sal_vld_q[sal_wa] <= 1'b1;
			if (prob_we) prob_vld_q[rd_addr] <= 1'b1;

			if (div_go) begin
				div_rem_q <= DSW'(div_dvd >> QW);
				div_num_q <= div_dvd[QW-1:0];
				div_den_q <= div_den;
				div_cnt_q <= '0;
				div_ret_q <= div_ret;
				state_q <= S_DIV;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req.valid) begin
							status_q <= req_status;
							sel_q    <= (req.func == gas_pkg::FUNC_SELECT);
							case (req.func)
								gas_pkg::FUNC_RESTART: begin
									sal_vld_q  <= '0;
									prob_vld_q <= '0;
									mod_q      <= base_s;
									state_q    <= S_DONE;
								end
								gas_pkg::FUNC_WR_SAL: state_q <= S_DONE;
								gas_pkg::FUNC_ADD_MOD: begin
									mod_q   <= clamp_s(mod_sum);
									state_q <= S_DONE;
								end
								gas_pkg::FUNC_SET_INH: begin
									if (gie_q) gi_q <= amt_c;
									state_q <= S_DONE;
								end
								gas_pkg::FUNC_UPDATE: begin
									amt_q   <= req.amount;
									state_q <= S_GAIN;
								end
								gas_pkg::FUNC_SELECT: begin
									cnt_q   <= '0;
									best_q  <= '0;
									win_q   <= '0;
									state_q <= (n_used != '0) ? S_SEL_RD : S_DONE;
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
					S_GAIN: begin
						g1_q     <= (VW+1)'(prod1 >> FB);
						g2_q     <= VW'(prod2 >> FB);
						cnt_q    <= '0;
						total_q  <= '0;
						inhsum_q <= '0;
						mx_q     <= '0;
						second_q <= '0;
						state_q  <= (n_used == '0) ? S_CONF : S_P1_RD;
					end
					S_P1_RD: state_q <= S_P1_MUL;
					S_P1_MUL: begin
						p1h_s2  <= (VW+1)'(p1 >> FB);
						p2h_s2  <= VW'(p2 >> FB);
						state_q <= S_P1_ACC;
					end
					S_P1_ACC: begin
						total_q  <= total_nx;
						inhsum_q <= inhsum_nx;
						if (act_v > mx_q) begin
							second_q <= mx_q;
							mx_q     <= act_v;
						end else if (act_v > second_q) begin
							second_q <= act_v;
						end
						if (cnt_nx == n_used) begin
							cnt_q   <= '0;
							state_q <= (total_nx > TW'(gas_pkg::EPS)) ? S_P2_RD : S_CONF;
						end else begin
							cnt_q   <= cnt_nx;
							state_q <= S_P1_RD;
						end
					end
					S_P2_RD: state_q <= S_P2_LD;
					S_P2_WR: begin
						if (cnt_nx == n_used) begin
							state_q <= S_CONF;
						end else begin
							cnt_q   <= cnt_nx;
							state_q <= S_P2_RD;
						end
					end
					S_CONF: begin
						conflict_q <= '0;
						state_q    <= S_MEAN;
					end
					S_CONF_WR: begin
						conflict_q <= div_num_q;
						state_q    <= S_MEAN;
					end
					S_MEAN: begin
						mean_q  <= '0;
						state_q <= S_DECAY;
					end
					S_MEAN_WR: begin
						mean_q  <= div_num_q;
						state_q <= S_DECAY;
					end
					S_DECAY: begin
						// magnitude over 2^16 first, then the divide by ten
						dabs_q    <= (VW+1)'(dprod_abs >> FB);
						dec_neg_q <= dprod[2*gas_pkg::AMTW+1];
						state_q   <= S_DECAY_MUL;
					end
					S_DECAY_MUL: begin
						dec_q   <= VW'(dec_prod >> DEC_SH);
						state_q <= S_DECAY_WR;
					end
					S_DECAY_WR: begin
						mod_q   <= clamp_s(mod_dec);
						state_q <= S_DONE;
					end
					S_SEL_RD: state_q <= S_SEL_CMP;
					S_SEL_CMP: begin
						// strict greater keeps the lowest channel on ties
						if (prob_val > best_q) begin
							best_q <= prob_val;
							win_q  <= gas_pkg::IDXW'(cnt_q);
						end
						cnt_q   <= cnt_nx;
						state_q <= (cnt_nx == n_used) ? S_DONE : S_SEL_RD;
					end
					S_DIV: begin
						div_rem_q <= div_ge ? DSW'(div_t - {1'b0, div_den_q}) : DSW'(div_t);
						div_num_q <= {div_num_q[QW-2:0], div_ge};
						div_cnt_q <= div_cnt_q + 1'b1;
						if (div_cnt_q == DCW'(QW - 1)) state_q <= div_ret_q;
					end
					S_DONE: begin
						// hold until the response slot is free
						if (!rsp_valid_q || rsp.ready) begin
							rsp_valid_q    <= 1'b1;
							rsp_status_q   <= status_q;
							rsp_winner_q   <= sel_q ? win_q : '0;
							rsp_conf_q     <= sel_q ? best_q : '0;
							rsp_weak_q     <= sel_q && (best_q < thr_q);
							rsp_conflict_q <= conflict_q;
							rsp_mean_q     <= mean_q;
							rsp_mod_q      <= mod_q;
							state_q        <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_status_q;
	assign rsp.winner            = rsp_winner_q;
	assign rsp.winner_confidence = rsp_conf_q;
	assign rsp.weak_winner       = rsp_weak_q;
	assign rsp.conflict          = rsp_conflict_q;
	assign rsp.mean_inhibition   = rsp_mean_q;
	assign rsp.modulator_now     = rsp_mod_q;

endmodule
